// ===== hdl/mitb_pkg.sv =====
package mitb_pkg;

    // Field widths of the stream payload.
    localparam int TIME_W      = 64;
    localparam int IVAL_W      = 24;
    localparam int SLOT_W      = 4;
    localparam int KIND_W      = 2;
    localparam int CMD_W       = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 136;

    // Clock constants.
    localparam int MS_PER_SEC = 1000;
    localparam int MILLI_W    = 10;

    // Table depth default.
    localparam int DEF_ENTRIES = 16;

    // Remainder unit: one dividend bit per cycle.
    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Request codes carried in the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_REG  = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    // Result kinds carried in the output tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED    = 2'd0,
        KIND_REGGED   = 2'd1,
        KIND_REJECTED = 2'd2,
        KIND_TIME     = 2'd3
    } kind_t;

    // Source of the slot field of a result.
    typedef enum logic [1:0] {
        SLOT_ZERO  = 2'd0,
        SLOT_COUNT = 2'd1,
        SLOT_PEND  = 2'd2
    } slot_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      item_load;
        logic      div_start;
        logic      div_src_entry;
        logic      ram_rd;
        logic      ram_wr;
        logic      idx_load;
        logic      idx_dec;
        logic      pend_set;
        logic      pend_clear;
        logic      out_load;
        kind_t     out_kind;
        slot_sel_t out_slot_sel;
        logic      out_last;
        logic      time_adv;
        logic      count_inc;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic             in_ival_zero;
        logic             full;
        logic             count_zero;
        logic             idx_zero;
        logic             div_done;
        logic             rem_zero;
        logic             pend_valid;
        logic             out_free;
    } dp_stat_t;

endpackage

// ===== hdl/mitb_ram.sv =====
module mitb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mitb_divider.sv =====
module mitb_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mitb_pkg::TIME_W-1:0] dividend,
    input  logic [mitb_pkg::IVAL_W-1:0] divisor,
    output logic                        done,
    output logic [mitb_pkg::IVAL_W-1:0] remainder
);

    import mitb_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TIME_W-1:0]    dvd_reg;
    logic [IVAL_W-1:0]    dvs_reg;
    logic [IVAL_W-1:0]    rem_reg;
    logic [IVAL_W:0]      trial;
    logic [IVAL_W:0]      diff;
    logic [IVAL_W-1:0]    rem_next;

    // Restoring step: bring in the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[TIME_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = diff[IVAL_W] ? trial[IVAL_W-1:0] : diff[IVAL_W-1:0];
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/mitb_datapath.sv =====
module mitb_datapath #(
    parameter int ENTRIES = mitb_pkg::DEF_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mitb_pkg::dp_cmd_t                cmd,
    output mitb_pkg::dp_stat_t               stat,
    input  logic [mitb_pkg::IN_TDATA_W-1:0]  in_tdata,
    input  logic [mitb_pkg::CMD_W-1:0]       in_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mitb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [mitb_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                             m_axis_tlast
);

    import mitb_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = 2 * IVAL_W;

    // Clock and table bookkeeping.
    logic [TIME_W-1:0]  sec_reg;
    logic [TIME_W-1:0]  total_reg;
    logic [MILLI_W-1:0] milli_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_m1;
    logic [AW-1:0]      idx_reg;
    logic               pend_valid_reg;
    logic [AW-1:0]      pend_idx_reg;
    logic [IVAL_W-1:0]  ival_reg;

    // Output register.
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [TIME_W-1:0]  out_sec_reg;
    logic [TIME_W-1:0]  out_total_reg;
    logic               out_last_reg;
    logic [SLOT_W-1:0]  slot_mux;

    // Entry memory and remainder unit.
    logic [EW-1:0]      rd_word;
    logic [IVAL_W-1:0]  ent_period;
    logic [IVAL_W-1:0]  ent_phase;
    logic [TIME_W-1:0]  div_dividend;
    logic [IVAL_W-1:0]  div_divisor;
    logic               div_done;
    logic [IVAL_W-1:0]  div_rem;

    assign ent_period = rd_word[EW-1:IVAL_W];
    assign ent_phase  = rd_word[IVAL_W-1:0];
    assign count_m1   = count_reg - CW'(1);

    // Dividend is the current time, offset by the phase when testing an entry.
    always_comb
    begin
        if (cmd.div_src_entry)
        begin
            div_dividend = total_reg + {{(TIME_W - IVAL_W){1'b0}}, ent_phase};
            div_divisor  = ent_period;
        end
        else
        begin
            div_dividend = total_reg;
            div_divisor  = in_tdata[IVAL_W-1:0];
        end
    end

    mitb_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    mitb_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.ram_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({ival_reg, div_rem}),
        .rd_en   (cmd.ram_rd),
        .rd_addr (idx_reg),
        .rd_data (rd_word)
    );

    // Time counters, fill count, walk index and pending fired entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg        <= '0;
            total_reg      <= '0;
            milli_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.time_adv)
            begin
                total_reg <= total_reg + TIME_W'(1);
                if (milli_reg == MILLI_W'(MS_PER_SEC - 1))
                begin
                    milli_reg <= '0;
                    sec_reg   <= sec_reg + TIME_W'(1);
                end
                else
                begin
                    milli_reg <= milli_reg + MILLI_W'(1);
                end
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.idx_load)
            begin
                idx_reg <= count_m1[AW-1:0];
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - AW'(1);
            end
            if (cmd.pend_set)
            begin
                pend_valid_reg <= 1'b1;
                pend_idx_reg   <= idx_reg;
            end
            else if (cmd.pend_clear)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Latched interval of the current request.
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            ival_reg <= in_tdata[IVAL_W-1:0];
        end
    end

    // Slot field of the next result.
    always_comb
    begin
        case (cmd.out_slot_sel)
            SLOT_COUNT: slot_mux = SLOT_W'(count_reg);
            SLOT_PEND:  slot_mux = SLOT_W'(pend_idx_reg);
            default:    slot_mux = '0;
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload captures the time before any advance.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg  <= cmd.out_kind;
            out_slot_reg  <= slot_mux;
            out_sec_reg   <= sec_reg;
            out_total_reg <= total_reg;
            out_last_reg  <= cmd.out_last;
        end
    end

    // Status back to the controller.
    always_comb
    begin
        stat.in_cmd       = in_tuser;
        stat.in_ival_zero = (in_tdata[IVAL_W-1:0] == '0);
        stat.full         = (count_reg == CW'(ENTRIES));
        stat.count_zero   = (count_reg == '0);
        stat.idx_zero     = (idx_reg == '0);
        stat.div_done     = div_done;
        stat.rem_zero     = (div_rem == '0);
        stat.pend_valid   = pend_valid_reg;
        stat.out_free     = !out_valid_reg || m_axis_tready;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SLOT_W - 2 * TIME_W){1'b0}},
                            out_total_reg, out_sec_reg, out_slot_reg};

endmodule

// ===== hdl/mitb_ctrl.sv =====
module mitb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mitb_pkg::dp_stat_t stat,
    output mitb_pkg::dp_cmd_t  cmd
);

    import mitb_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_RD      = 10'b0000000010,
        S_CHK     = 10'b0000000100,
        S_DIV     = 10'b0000001000,
        S_PUSH    = 10'b0000010000,
        S_FLUSH   = 10'b0000100000,
        S_DIV_REG = 10'b0001000000,
        S_EM_REG  = 10'b0010000000,
        S_EM_REJ  = 10'b0100000000,
        S_EM_TIME = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after_entry;

    // Where the walk goes after one entry: the next lower slot or the flush.
    assign after_entry = stat.idx_zero ? S_FLUSH : S_RD;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.out_kind      = KIND_FIRED;
        cmd.out_slot_sel  = SLOT_ZERO;
        in_ready          = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    case (stat.in_cmd)
                        CMD_TICK:
                        begin
                            if (stat.count_zero)
                            begin
                                cmd.time_adv = 1'b1;
                            end
                            else
                            begin
                                cmd.idx_load = 1'b1;
                                state_next   = S_RD;
                            end
                        end
                        CMD_REG:
                        begin
                            if (stat.in_ival_zero || stat.full)
                            begin
                                state_next = S_EM_REJ;
                            end
                            else
                            begin
                                cmd.div_start = 1'b1;
                                state_next    = S_DIV_REG;
                            end
                        end
                        CMD_READ:
                        begin
                            state_next = S_EM_TIME;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Fetch the entry at the walk index.
            S_RD:
            begin
                cmd.ram_rd = 1'b1;
                state_next = S_CHK;
            end

            // Start the remainder of time plus phase over the period.
            S_CHK:
            begin
                cmd.div_src_entry = 1'b1;
                cmd.div_start     = 1'b1;
                state_next        = S_DIV;
            end

            // A zero remainder fires the entry; one fired entry is held back
            // so that the final result of the tick can carry the last flag.
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_zero && stat.pend_valid)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        if (stat.rem_zero)
                        begin
                            cmd.pend_set = 1'b1;
                        end
                        cmd.idx_dec = !stat.idx_zero;
                        state_next  = after_entry;
                    end
                end
            end

            // Send the held entry and hold the new one.
            S_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_kind     = KIND_FIRED;
                    cmd.out_slot_sel = SLOT_PEND;
                    cmd.pend_set     = 1'b1;
                    cmd.idx_dec      = !stat.idx_zero;
                    state_next       = after_entry;
                end
            end

            // End of tick: send the held entry, if any, as last, and advance time.
            S_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    cmd.time_adv = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_kind     = KIND_FIRED;
                    cmd.out_slot_sel = SLOT_PEND;
                    cmd.out_last     = 1'b1;
                    cmd.pend_clear   = 1'b1;
                    cmd.time_adv     = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            // Wait for the phase of a new entry.
            S_DIV_REG:
            begin
                if (stat.div_done)
                begin
                    state_next = S_EM_REG;
                end
            end

            // Store the entry and report its slot.
            S_EM_REG:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_kind     = KIND_REGGED;
                    cmd.out_slot_sel = SLOT_COUNT;
                    cmd.out_last     = 1'b1;
                    cmd.ram_wr       = 1'b1;
                    cmd.count_inc    = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            S_EM_REJ:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_REJECTED;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_EM_TIME:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_TIME;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/millisecond_interval_timer_bank.sv =====
// A time read only goes through the output register; a register request
// waits on the bit-serial 64-step remainder unit computing the phase.
// A tick fetches each table entry in use and runs one 64-step remainder on it,
// and with an empty table it only advances the time.
// One request is handled at a time; a result waits in the output register.
// Reset (rst_n, asynchronous, active low) clears time, fill count and state.
module millisecond_interval_timer_bank #(
    parameter int ENTRIES = mitb_pkg::DEF_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0: interval_ms[23:0].
    input  logic [mitb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: cmd[1:0].
    input  logic [mitb_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: slot[3:0], seconds[67:4], total_ms[131:68], zero pad.
    output logic [mitb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: kind[1:0].
    output logic [mitb_pkg::KIND_W-1:0]      m_axis_tuser,
    output logic                             m_axis_tlast
);

    import mitb_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Request sequencing.
    mitb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // Counters, entry table, remainder unit and output register.
    mitb_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .in_tdata      (s_axis_tdata),
        .in_tuser      (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== test/tb_millisecond_interval_timer_bank.sv =====
module tb_millisecond_interval_timer_bank;

    timeunit 1ns;
    timeprecision 1ps;

    import mitb_pkg::*;

    // Command value that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SLOTS = DEF_ENTRIES;
    // Cycles to keep watching for stray results once everything has arrived.
    localparam int SETTLE_CYCLES = 1200;
    localparam int HOLD_CYCLES = 400;

    // One result as the block should report it.
    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] seconds;
        logic [TIME_W-1:0] total_ms;
        logic              last;
    } timer_result_t;

    // How a row of the directed table is checked.
    typedef enum logic [1:0] {
        FROM_MODEL,
        NO_RESULT,
        ONE_RESULT
    } row_check_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [IVAL_W-1:0] ival;
        int                reps;
        row_check_t        check;
        timer_result_t     want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    // Predicted state of the timer bank.
    logic [TIME_W-1:0]  sec_count = '0;
    logic [MILLI_W-1:0] milli_count = '0;
    int                 used_slots = 0;
    logic [IVAL_W-1:0]  period_tab [SLOTS];
    logic [IVAL_W-1:0]  phase_tab [SLOTS];

    timer_result_t fresh_results[$];
    timer_result_t pending_results[$];
    stim_row_t     plan[$];
    int            err_count = 0;
    bit            calm = 1'b0;
    int            hold_request = 0;

    millisecond_interval_timer_bank dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Works out the results of one accepted request and advances the time on a tick.
    function automatic void predict_timer(input logic [CMD_W-1:0] cmd,
                                          input logic [IVAL_W-1:0] ival);
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] sum;
        int                idx;
        fresh_results = {};
        now_ms = sec_count * 64'd1000 + 64'(milli_count);
        case (cmd)
            CMD_TICK:
            begin
                // Newest slot is tested first.
                for (idx = used_slots - 1; idx >= 0; idx--)
                begin
                    sum = now_ms + 64'(phase_tab[idx]);
                    if (sum % 64'(period_tab[idx]) == 64'd0)
                        fresh_results.push_back('{KIND_FIRED, SLOT_W'(idx), sec_count,
                                                  now_ms, 1'b0});
                end
                if (milli_count == MILLI_W'(MS_PER_SEC - 1))
                begin
                    milli_count = '0;
                    sec_count = sec_count + 64'd1;
                end
                else
                begin
                    milli_count = milli_count + 1'b1;
                end
            end
            CMD_REG:
            begin
                if (ival == '0 || used_slots >= SLOTS)
                begin
                    fresh_results.push_back('{KIND_REJECTED, '0, sec_count, now_ms, 1'b0});
                end
                else
                begin
                    period_tab[used_slots] = ival;
                    phase_tab[used_slots] = IVAL_W'(now_ms % 64'(ival));
                    fresh_results.push_back('{KIND_REGGED, SLOT_W'(used_slots), sec_count,
                                              now_ms, 1'b0});
                    used_slots++;
                end
            end
            CMD_READ:
            begin
                fresh_results.push_back('{KIND_TIME, '0, sec_count, now_ms, 1'b0});
            end
            default:
            begin
            end
        endcase
        if (fresh_results.size() > 0)
            fresh_results[fresh_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void plan_row(input logic [CMD_W-1:0] cmd, input logic [IVAL_W-1:0] ival,
                                     input int reps, input row_check_t check,
                                     input kind_t kind, input logic [SLOT_W-1:0] slot,
                                     input logic [TIME_W-1:0] seconds,
                                     input logic [TIME_W-1:0] total_ms);
        stim_row_t row;
        row.cmd = cmd;
        row.ival = ival;
        row.reps = reps;
        row.check = check;
        row.want = '{kind, slot, seconds, total_ms, 1'b1};
        plan.push_back(row);
    endfunction

    // Mostly short periods so that entries fire often, with some long ones.
    function automatic logic [IVAL_W-1:0] pick_interval();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5)
            return '0;
        if (p < 70)
            return IVAL_W'($urandom_range(1, 24));
        if (p < 88)
            return IVAL_W'($urandom_range(25, 5000));
        return IVAL_W'($urandom_range(1, 24'hFFFFFF));
    endfunction

    function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Offers one request, sometimes after a random gap, and returns at its acceptance.
    task automatic drive_request(input logic [CMD_W-1:0] cmd, input logic [IVAL_W-1:0] ival);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 20)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ival;
        s_axis_tuser <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IVAL_W-1:0] ival);
        drive_request(cmd, ival);
        predict_timer(cmd, ival);
        foreach (fresh_results[i])
            pending_results.push_back(fresh_results[i]);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side ready, with random stalls and an occasional long hold-off.
    initial
    begin : sink_ready
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Compares each accepted result with the oldest expectation.
    initial
    begin : result_monitor
        timer_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d, slot %0d, total_ms %0d",
                           m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[131:68]);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
                    check_field("slot", 64'(want.slot), 64'(m_axis_tdata[3:0]));
                    check_field("seconds", want.seconds, m_axis_tdata[67:4]);
                    check_field("total_ms", want.total_ms, m_axis_tdata[131:68]);
                    check_field("last", 64'(want.last), 64'(m_axis_tlast));
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [CMD_W-1:0]  cmd;
        logic [IVAL_W-1:0] ival;
        int                pick;

        // Directed table. Rows before the first registration start from reset,
        // so their results are known outright; the tick burst walks the clock up
        // to the carry into seconds while the table is still empty.
        plan_row(CMD_READ, '0, 1, ONE_RESULT, KIND_TIME, '0, 64'd0, 64'd0);
        plan_row(CMD_REG, '0, 1, ONE_RESULT, KIND_REJECTED, '0, 64'd0, 64'd0);
        plan_row(CMD_UNUSED, 24'hFFFFFF, 1, NO_RESULT, KIND_FIRED, '0, 64'd0, 64'd0);
        plan_row(CMD_TICK, '0, 1, NO_RESULT, KIND_FIRED, '0, 64'd0, 64'd0);
        plan_row(CMD_TICK, 24'hFFFFFF, 998, NO_RESULT, KIND_FIRED, '0, 64'd0, 64'd0);
        plan_row(CMD_READ, 24'hFFFFFF, 1, ONE_RESULT, KIND_TIME, '0, 64'd0, 64'd999);
        plan_row(CMD_TICK, '0, 1, NO_RESULT, KIND_FIRED, '0, 64'd0, 64'd0);
        plan_row(CMD_READ, '0, 1, ONE_RESULT, KIND_TIME, '0, 64'd1, 64'd1000);
        plan_row(CMD_REG, 24'd1, 1, ONE_RESULT, KIND_REGGED, 4'd0, 64'd1, 64'd1000);
        plan_row(CMD_REG, 24'hFFFFFF, 1, ONE_RESULT, KIND_REGGED, 4'd1, 64'd1, 64'd1000);
        plan_row(CMD_REG, '0, 1, ONE_RESULT, KIND_REJECTED, '0, 64'd1, 64'd1000);
        plan_row(CMD_REG, 24'd3, 1, FROM_MODEL, KIND_FIRED, '0, 64'd0, 64'd0);
        plan_row(CMD_REG, 24'd7, 1, FROM_MODEL, KIND_FIRED, '0, 64'd0, 64'd0);
        plan_row(CMD_TICK, 24'h5A5A5A, 4, FROM_MODEL, KIND_FIRED, '0, 64'd0, 64'd0);
        plan_row(CMD_UNUSED, '0, 1, NO_RESULT, KIND_FIRED, '0, 64'd0, 64'd0);
        plan_row(CMD_READ, '0, 1, FROM_MODEL, KIND_FIRED, '0, 64'd0, 64'd0);
        plan_row(CMD_REG, 24'd2, 1, FROM_MODEL, KIND_FIRED, '0, 64'd0, 64'd0);
        plan_row(CMD_TICK, 24'hA5A5A5, 6, FROM_MODEL, KIND_FIRED, '0, 64'd0, 64'd0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            repeat (plan[r].reps)
            begin
                drive_request(plan[r].cmd, plan[r].ival);
                predict_timer(plan[r].cmd, plan[r].ival);
                if (plan[r].check == FROM_MODEL)
                begin
                    foreach (fresh_results[i])
                        pending_results.push_back(fresh_results[i]);
                end
                else if (plan[r].check == ONE_RESULT)
                begin
                    pending_results.push_back(plan[r].want);
                end
            end
        end

        // Random part: mostly ticks and registrations, with reads and noise.
        for (int n = 0; n < 200; n++)
        begin
            calm = (n >= 140 && n < 175);
            if (n == 60)
            begin
                // Hold the result side off while requests keep coming.
                hold_request = HOLD_CYCLES;
                repeat (12) issue(CMD_READ, IVAL_W'($urandom()));
            end
            if (n == 120)
            begin
                // Stop offering requests until every result has come back.
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 60)
                cmd = CMD_TICK;
            else if (pick < 80)
                cmd = CMD_REG;
            else if (pick < 95)
                cmd = CMD_READ;
            else
                cmd = CMD_UNUSED;
            ival = (cmd == CMD_REG) ? pick_interval() : IVAL_W'($urandom());
            issue(cmd, ival);
        end
        calm = 1'b0;

        // Fill the table, overflow it once, and let the full table fire.
        while (used_slots < SLOTS)
            issue(CMD_REG, pick_interval());
        issue(CMD_REG, 24'd5);
        repeat (4) issue(CMD_TICK, IVAL_W'($urandom()));

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mitb_pkg.sv
hdl/mitb_ram.sv
hdl/mitb_divider.sv
hdl/mitb_datapath.sv
hdl/mitb_ctrl.sv
hdl/millisecond_interval_timer_bank.sv
test/tb_millisecond_interval_timer_bank.sv
